@@ rtl/iircf_pkg.sv @@
// Shared constants, types and helpers for the IIR comb filter with header bypass.
// No dependencies; every other file imports this package.
package iircf_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 32;
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 4;
  localparam int GAIN_SHIFT = 3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_HEADER_ITEMS  = 2'd0;
  localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [1:0] REG_DIRECT_GAIN   = 2'd2;
  localparam logic [1:0] REG_DELAYED_GAIN  = 2'd3;

  localparam logic [7:0]          HEADER_ITEMS_RST  = 8'd44;
  localparam logic [SAMPLE_W-1:0] FEEDBACK_GAIN_RST = 16'sd0;
  localparam logic [SAMPLE_W-1:0] DIRECT_GAIN_RST   = 16'sd8;
  localparam logic [SAMPLE_W-1:0] DELAYED_GAIN_RST  = 16'sd0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ACC_W-1:0]           acc_t;
  typedef logic [RING_AW-1:0]         ring_addr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SUM
  } filt_state_t;

  function automatic acc_t asr_gain(input acc_t v);
    asr_gain = {{GAIN_SHIFT{v[ACC_W-1]}}, v[ACC_W-1:GAIN_SHIFT]};
  endfunction

  function automatic acc_t sext_sample(input logic [SAMPLE_W-1:0] v);
    sext_sample = {{(ACC_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

endpackage

@@ rtl/iircf_in_if.sv @@
// Input sample channel: valid/ready handshake carrying one sample word.
// Depends on iircf_pkg for the sample type.
interface iircf_in_if;
  import iircf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

@@ rtl/iircf_out_if.sv @@
// Result sample channel: valid/ready handshake carrying one sample word.
// Depends on iircf_pkg for the sample type.
interface iircf_out_if;
  import iircf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/iir_comb_filter_with_header_bypass.sv @@
// Channel  Dir  Handshake                  Payload
// in_ch    in   valid & ready              sample_in, 16 bit signed
// out_ch   out  valid & ready              sample_out, 16 bit signed
// cfg_*    in   psel & penable & pwrite    4 registers at byte address 4*i
//
// A header word is copied to the output register; a filtered word passes from
// accept through the ring RAM read, two dependent multiply stages and the final
// sum before the next word can be taken. The result lands in an output register,
// so a new filtered word is taken while the previous result waits. Reset is synchronous,
// active low; the 64 ring valid bits clear at once, so no clearing pass is needed.
// A stalled output holds the final stage until the register drains.
// Depends on iircf_pkg, iircf_in_if and iircf_out_if.
module iir_comb_filter_with_header_bypass (
  input  logic                        clk,
  input  logic                        rst_n,
  iircf_in_if.sink                    in_ch,
  iircf_out_if.source                 out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [iircf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [iircf_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [iircf_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import iircf_pkg::*;

  // configuration registers
  logic [7:0]          header_items_r;
  logic [SAMPLE_W-1:0] feedback_gain_r;
  logic [SAMPLE_W-1:0] direct_gain_r;
  logic [SAMPLE_W-1:0] delayed_gain_r;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_items_r  <= HEADER_ITEMS_RST;
      feedback_gain_r <= FEEDBACK_GAIN_RST;
      direct_gain_r   <= DIRECT_GAIN_RST;
      delayed_gain_r  <= DELAYED_GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HEADER_ITEMS:  header_items_r  <= cfg_pwdata[7:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_pwdata[SAMPLE_W-1:0];
        REG_DIRECT_GAIN:   direct_gain_r   <= cfg_pwdata[SAMPLE_W-1:0];
        REG_DELAYED_GAIN:  delayed_gain_r  <= cfg_pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HEADER_ITEMS:  cfg_prdata = {24'd0, header_items_r};
      REG_FEEDBACK_GAIN: cfg_prdata = sext_sample(feedback_gain_r);
      REG_DIRECT_GAIN:   cfg_prdata = sext_sample(direct_gain_r);
      REG_DELAYED_GAIN:  cfg_prdata = sext_sample(delayed_gain_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // control and datapath state
  filt_state_t       state_r, state_nxt;
  ring_addr_t        pos_r, pos_nxt, q_addr;
  logic [7:0]        hcnt_r, hcnt_nxt;
  logic              mode_r, mode_nxt;
  logic              out_valid_r, out_valid_nxt;
  sample_t           out_data_r, out_data_nxt;
  logic [RING_DEPTH-1:0] ring_valid_r;

  acc_t              ring_mem [RING_DEPTH];
  acc_t              rd_r;
  logic              oldv_r;
  acc_t              x_r, fbp_r, dlp_r, wdp_r;
  acc_t              oldest, w_val, y_val;
  logic              bypass_now, in_acc, mem_we, out_free;

  assign q_addr     = (pos_r == RING_AW'(RING_DEPTH-1)) ? '0 : pos_r + 1'b1;
  assign bypass_now = !mode_r && (hcnt_r < header_items_r);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign oldest     = oldv_r ? rd_r : '0;
  assign w_val      = x_r + asr_gain(fbp_r);
  assign y_val      = asr_gain(wdp_r) + dlp_r;
  assign mem_we     = (state_r == S_MUL2);

  assign in_ch.ready       = (state_r == S_IDLE) && (!bypass_now || out_free);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    hcnt_nxt      = hcnt_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (bypass_now) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = in_ch.sample_in;
            hcnt_nxt      = hcnt_r + 8'd1;
            if (hcnt_r + 8'd1 == header_items_r) mode_nxt = 1'b1;
          end else begin
            mode_nxt  = 1'b1;
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: begin
        pos_nxt   = q_addr;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // hold the final sum until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = y_val[SAMPLE_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      hcnt_r       <= '0;
      mode_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      ring_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      hcnt_r      <= hcnt_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) ring_valid_r[pos_r] <= 1'b1;
    end
  end

  // ring RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[pos_r] <= w_val;
    if (in_acc) rd_r <= ring_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      x_r    <= sext_sample(in_ch.sample_in);
      oldv_r <= ring_valid_r[q_addr];
    end
    if (state_r == S_MUL1) begin
      fbp_r <= ACC_W'(oldest * sext_sample(feedback_gain_r));
      dlp_r <= asr_gain(ACC_W'(oldest * sext_sample(delayed_gain_r)));
    end
    if (state_r == S_MUL2) wdp_r <= ACC_W'(w_val * sext_sample(direct_gain_r));
  end

  a_filter_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !bypass_now |=> state_r == S_MUL1)
    else $error("filtered word did not start the multiply sequence");

  a_bypass_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && bypass_now |=> out_valid_r && out_data_r == $past(in_ch.sample_in))
    else $error("header word not copied to output");

  a_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |=> mode_r)
    else $error("filter mode fell back to bypass");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL2 |=> pos_r == $past(q_addr) && ring_valid_r[$past(pos_r)])
    else $error("ring position or valid bit not updated after write");

endmodule
